// File: design/rmf_pkg.sv
// ----------------------------------------------------------------------------
// rmf_pkg
// Shared widths and job record for the radiation model flow block.
// ----------------------------------------------------------------------------
`default_nettype none
package rmf_pkg;
  localparam int EMP_BITS = 24;
  localparam int POP_BITS = 32;
  localparam int IDX_BITS = 16;
  localparam int TOT_BITS = 40;
  localparam int SUM_BITS = 40;
  localparam int FLOW_BITS = 48;
  localparam int ACC_BITS = 128;
  localparam int DIV_BITS = SUM_BITS + 1;
  localparam int MUL_BITS = TOT_BITS;
  localparam int FRAC_SHIFT = 8;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [IDX_BITS-1:0] index;
    logic [POP_BITS-1:0] pop;
    logic [EMP_BITS-1:0] m;
    logic [EMP_BITS-1:0] n;
    logic [SUM_BITS-1:0] s;
    logic                origin;
  } rmf_job_t;
endpackage
`default_nettype wire

// File: design/rmf_queue.sv
// ----------------------------------------------------------------------------
// rmf_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module rmf_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire rmf_pkg::rmf_job_t push_job,
  input  wire logic             pop,
  output rmf_pkg::rmf_job_t     head_job,
  output logic                  valid,
  output logic                  full
);
  rmf_pkg::rmf_job_t mem [rmf_pkg::QUEUE_DEPTH];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  assign head_job = mem[rd_ptr];
  assign valid = (count != 2'd0);
  assign full = (count == 2'd2);
endmodule
`default_nettype wire

// File: design/rmf_front.sv
// ----------------------------------------------------------------------------
// rmf_front
// Accept items, keep the running employment sum, issue jobs.
// ----------------------------------------------------------------------------
`default_nettype none
module rmf_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [95:0]       s_axis_tdata,
  input  wire logic [1:0]        s_axis_tuser,
  input  wire logic              queue_full,
  output logic                   push,
  output rmf_pkg::rmf_job_t      push_job
);
  logic [rmf_pkg::SUM_BITS-1:0] sum;
  logic [rmf_pkg::SUM_BITS-1:0] s_eff;
  logic [rmf_pkg::SUM_BITS:0] sum_wide;

  assign s_axis_tready = !queue_full;
  assign push = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s_eff = s_axis_tuser[0] ? '0 : sum;
    push_job.pop = s_axis_tdata[31:0];
    push_job.m = s_axis_tdata[55:32];
    push_job.index = s_axis_tdata[71:56];
    push_job.n = s_axis_tdata[95:72];
    push_job.origin = s_axis_tuser[1];
    push_job.s = s_eff;
    sum_wide = {1'b0, s_eff}
             + {{(rmf_pkg::SUM_BITS + 1 - rmf_pkg::EMP_BITS){1'b0}}, push_job.n};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (push) begin
      sum <= sum_wide[rmf_pkg::SUM_BITS] ? '1 : sum_wide[rmf_pkg::SUM_BITS-1:0];
    end
  end
endmodule
`default_nettype wire

// File: design/rmf_back.sv
// ----------------------------------------------------------------------------
// rmf_back
// Shift-add multiply and restoring divide of one job, then output register.
// ----------------------------------------------------------------------------
`default_nettype none
module rmf_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [rmf_pkg::TOT_BITS-1:0]  total,
  input  wire logic                          job_valid,
  input  wire rmf_pkg::rmf_job_t             job,
  output logic                               job_pop,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [63:0]                        m_axis_tdata,
  output logic                               m_axis_tuser
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL = 2'd1;
  localparam logic [1:0] ST_DIV = 2'd2;
  localparam logic [1:0] ST_OUT = 2'd3;
  localparam int A = rmf_pkg::ACC_BITS;
  localparam int D = rmf_pkg::DIV_BITS;

  logic [1:0] state;
  logic [1:0] sel;
  logic [6:0] cnt;
  logic [A-1:0] x;
  logic [A-1:0] acc;
  logic [A-1:0] acc_next;
  logic [D-1:0] rem;
  logic [D:0] rem_sh;
  logic [D:0] dsel;
  logic ge;
  logic [rmf_pkg::MUL_BITS-1:0] mop [3];
  logic [D-1:0] dv [3];
  logic [rmf_pkg::IDX_BITS-1:0] res_index;
  logic [rmf_pkg::FLOW_BITS-1:0] res_flow;
  logic res_sat;
  logic [D-1:0] ms;
  logic special;

  always_comb begin
    ms = {{(D - rmf_pkg::EMP_BITS){1'b0}}, job.m} + {1'b0, job.s};
    special = (total <= {{(rmf_pkg::TOT_BITS - rmf_pkg::EMP_BITS){1'b0}}, job.m})
           || (ms == '0);
    acc_next = {acc[A-2:0], 1'b0} + (mop[sel][cnt[5:0]] ? x : '0);
    rem_sh = {rem, x[A-1]};
    dsel = {1'b0, dv[sel]};
    ge = (rem_sh >= dsel);
  end

  assign job_pop = (state == ST_IDLE) && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if ((state == ST_OUT) && (!m_axis_tvalid || m_axis_tready)) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            res_index <= job.index;
            x <= {{(A - rmf_pkg::POP_BITS){1'b0}}, job.pop};
            acc <= '0;
            sel <= 2'd0;
            cnt <= 7'(rmf_pkg::MUL_BITS - 1);
            mop[0] <= total;
            mop[1] <= {{(rmf_pkg::MUL_BITS - rmf_pkg::EMP_BITS){1'b0}}, job.m};
            mop[2] <= {{(rmf_pkg::MUL_BITS - rmf_pkg::EMP_BITS){1'b0}}, job.n};
            dv[0] <= {1'b0, total - {{(rmf_pkg::TOT_BITS - rmf_pkg::EMP_BITS){1'b0}}, job.m}};
            dv[1] <= ms;
            dv[2] <= ms + {{(D - rmf_pkg::EMP_BITS){1'b0}}, job.n};
            if (job.origin) begin
              res_flow <= '0;
              res_sat <= 1'b0;
              state <= ST_OUT;
            end else if (special) begin
              res_flow <= '1;
              res_sat <= 1'b1;
              state <= ST_OUT;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (cnt == 7'd0) begin
            acc <= '0;
            if (sel == 2'd2) begin
              x <= acc_next << rmf_pkg::FRAC_SHIFT;
              sel <= 2'd0;
              cnt <= 7'(A - 1);
              rem <= '0;
              state <= ST_DIV;
            end else begin
              x <= acc_next;
              sel <= sel + 2'd1;
              cnt <= 7'(rmf_pkg::MUL_BITS - 1);
            end
          end else begin
            acc <= acc_next;
            cnt <= cnt - 7'd1;
          end
        end
        ST_DIV: begin
          x <= {x[A-2:0], ge};
          if (cnt == 7'd0) begin
            rem <= '0;
            cnt <= 7'(A - 1);
            if (sel == 2'd2) begin
              if (x[A-2:rmf_pkg::FLOW_BITS-1] != '0) begin
                res_flow <= '1;
                res_sat <= 1'b1;
              end else begin
                res_flow <= {x[rmf_pkg::FLOW_BITS-2:0], ge};
                res_sat <= 1'b0;
              end
              state <= ST_OUT;
            end else begin
              sel <= sel + 2'd1;
            end
          end else begin
            rem <= ge ? D'(rem_sh - dsel) : rem_sh[D-1:0];
            cnt <= cnt - 7'd1;
          end
        end
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata <= {res_flow, res_index};
            m_axis_tuser <= res_sat;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: design/radiation_model_flow.sv
// ----------------------------------------------------------------------------
// radiation_model_flow
// Radiation model commuting flow per neighbor zone of one origin.
// ----------------------------------------------------------------------------
// Sequence for a computed item: job load, 3 x 40 shift-add multiply steps,
// 3 x 128 restoring divide steps, then output; origin items and items saturated
// by the total or zero-divisor rule go from job load straight to output.
// The single shared multiply/divide unit takes a new job only when idle;
// a two-entry queue lets input run ahead.
// Reset clears the running sum, queue and output valid; total resets to 1.
`default_nettype none
module radiation_model_flow (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [39:0] cfg_data,       // total_employment
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,   // origin_pop, origin_emp, neighbor_index, neighbor_emp
  input  wire logic [1:0]  s_axis_tuser,   // first_neighbor, is_origin
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // dest_index, flow
  output logic             m_axis_tuser    // saturated
);
  logic [rmf_pkg::TOT_BITS-1:0] total;
  logic q_full;
  logic q_valid;
  logic q_push;
  logic q_pop;
  rmf_pkg::rmf_job_t push_job;
  rmf_pkg::rmf_job_t head_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= rmf_pkg::TOT_BITS'(1);
    end else if (cfg_valid) begin
      total <= cfg_data;
    end
  end

  rmf_front u_front (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .queue_full(q_full), .push(q_push), .push_job(push_job)
  );

  rmf_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_job(push_job),
    .pop(q_pop), .head_job(head_job), .valid(q_valid), .full(q_full)
  );

  rmf_back u_back (
    .clk(clk), .rst(rst), .total(total),
    .job_valid(q_valid), .job(head_job), .job_pop(q_pop),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !s_axis_tready) else $error("accept while queue full");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid) else $error("output valid after reset");
endmodule
`default_nettype wire
